[rtl/core/aabb_frustum_cull_core_assert.svh]
// ----------------------------------------------------------------------------
// aabb_frustum_cull_core_assert.svh
// Assertion macros used by the cull core checker.
// ----------------------------------------------------------------------------
`ifndef AABB_FRUSTUM_CULL_CORE_ASSERT_SVH
`define AABB_FRUSTUM_CULL_CORE_ASSERT_SVH

// Clocked assertion that is switched off while reset is high
`define AFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset
`define AFC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/afc_pkg.sv]
// ----------------------------------------------------------------------------
// afc_pkg
// Shared widths, plane register layout and the word carried along the cells.
// ----------------------------------------------------------------------------
package afc_pkg;

  localparam int POS_W        = 16;
  localparam int NORM_W       = 16;
  localparam int FRAC_BITS    = 14;
  localparam int NUM_PLANES   = 6;
  localparam int PLANE_W      = 64;
  localparam int CFG_IDX_W    = 3;
  localparam int OUT_TDATA_W  = 8;
  localparam int DEF_CHUNK_XZ = 16;
  localparam int DEF_CHUNK_Y  = 256;

  // Plane register layout, most significant field first
  typedef struct packed {
    logic signed [NORM_W-1:0] off;
    logic signed [NORM_W-1:0] nz;
    logic signed [NORM_W-1:0] ny;
    logic signed [NORM_W-1:0] nx;
  } plane_t;

  // Word handed from cell to cell
  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic                    needs_rebuild;
    logic                    vis;
  } item_t;

endpackage

[rtl/core/afc_cell.sv]
// ----------------------------------------------------------------------------
// afc_cell
// One plane of the frustum: p-vertex products in the first stage, sum and
// sign test in the second, visibility flag ANDed into the passing word.
// ----------------------------------------------------------------------------
module afc_cell
  import afc_pkg::*;
#(
  parameter int CHUNK_XZ = DEF_CHUNK_XZ,
  parameter int CHUNK_Y  = DEF_CHUNK_Y
) (
  input  logic               clk,
  input  logic               rst,
  input  plane_t             plane,
  input  logic               in_valid,
  input  item_t              in_item,
  output logic               in_ready,
  output logic               out_valid,
  output item_t              out_item,
  input  logic               out_ready
);

  localparam int CHUNK_MAX = (CHUNK_XZ > CHUNK_Y) ? CHUNK_XZ : CHUNK_Y;
  localparam int COORD_W   = $clog2((1 << (POS_W - 1)) + CHUNK_MAX) + 1;
  localparam int PROD_W    = COORD_W + NORM_W;
  localparam int ACC_W     = PROD_W + 3;

  localparam logic signed [COORD_W-1:0] SIZE_XZ = COORD_W'(CHUNK_XZ);
  localparam logic signed [COORD_W-1:0] SIZE_Y  = COORD_W'(CHUNK_Y);

  logic                      a_valid;
  item_t                     a_item;
  logic signed [PROD_W-1:0]  prod_x, prod_y, prod_z;
  logic signed [NORM_W-1:0]  a_off;
  logic                      a_ready;
  logic                      b_ready;
  item_t                     b_item;

  logic signed [COORD_W-1:0] px, py, pz;
  logic signed [ACC_W-1:0]   sum;

  // Pick the box corner farthest along the normal
  always_comb begin
    px = COORD_W'(in_item.pos_x);
    py = COORD_W'(in_item.pos_y);
    pz = COORD_W'(in_item.pos_z);
    if (!plane.nx[NORM_W-1]) px = px + SIZE_XZ;
    if (!plane.ny[NORM_W-1]) py = py + SIZE_Y;
    if (!plane.nz[NORM_W-1]) pz = pz + SIZE_XZ;
  end

  // Advance a stage when it is empty or its successor takes the word
  assign b_ready  = !out_valid || out_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  // Product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_item <= in_item;
      prod_x <= plane.nx * px;
      prod_y <= plane.ny * py;
      prod_z <= plane.nz * pz;
      a_off  <= plane.off;
    end
  end

  // Sum the products and the scaled offset
  assign sum = ACC_W'(prod_x) + ACC_W'(prod_y) + ACC_W'(prod_z)
             + (ACC_W'(a_off) <<< FRAC_BITS);

  // Drop visibility when the p-vertex lies behind the plane
  always_comb begin
    b_item     = a_item;
    b_item.vis = a_item.vis & ~sum[ACC_W-1];
  end

  // Sign test stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_ready) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      out_item <= b_item;
    end
  end

endmodule

[rtl/core/aabb_frustum_cull_core.sv]
// ----------------------------------------------------------------------------
// aabb_frustum_cull_core
// Chunk box versus six-plane frustum test in a row of plane cells.
// ----------------------------------------------------------------------------
// One chunk word is taken per clock and one result word leaves per clock
// while the output is not stalled. Each of the six plane cells holds two
// registered stages (products, then sum and sign test), and a result passes
// through both stages of every cell in turn. Every stage stalls on its own, so
// empty slots in the row keep filling while a result waits at the output. Plane
// registers are written through the cfg channel, which is always ready;
// indexes beyond the last plane are ignored. After reset all planes are zero
// and every chunk is in view.
// ----------------------------------------------------------------------------
module aabb_frustum_cull_core
  import afc_pkg::*;
#(
  parameter int CHUNK_XZ = DEF_CHUNK_XZ,
  parameter int CHUNK_Y  = DEF_CHUNK_Y
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [PLANE_W-1:0]     cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [3*POS_W-1:0]     s_tdata,   // pos_x, pos_y, pos_z
  input  logic                   s_tuser,   // needs_rebuild
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // in_view, zero padding
  output logic                   m_tuser    // render
);

  plane_t planes [NUM_PLANES];

  logic  link_valid [NUM_PLANES+1];
  logic  link_ready [NUM_PLANES+1];
  item_t link_item  [NUM_PLANES+1];

  // Write plane registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        planes[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(NUM_PLANES))) begin
      planes[cfg_index] <= plane_t'(cfg_data);
    end
  end

  // Unpack the chunk word into the head of the row
  always_comb begin
    link_item[0].pos_x         = s_tdata[POS_W-1:0];
    link_item[0].pos_y         = s_tdata[2*POS_W-1:POS_W];
    link_item[0].pos_z         = s_tdata[3*POS_W-1:2*POS_W];
    link_item[0].needs_rebuild = s_tuser;
    link_item[0].vis           = 1'b1;
  end

  assign link_valid[0] = s_tvalid;
  assign s_tready      = link_ready[0];

  // Row of plane cells
  for (genvar g = 0; g < NUM_PLANES; g++) begin : g_cell
    afc_cell #(
      .CHUNK_XZ (CHUNK_XZ),
      .CHUNK_Y  (CHUNK_Y)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .plane     (planes[g]),
      .in_valid  (link_valid[g]),
      .in_item   (link_item[g]),
      .in_ready  (link_ready[g]),
      .out_valid (link_valid[g+1]),
      .out_item  (link_item[g+1]),
      .out_ready (link_ready[g+1])
    );
  end

  // Drive the result word from the tail of the row
  assign m_tvalid               = link_valid[NUM_PLANES];
  assign link_ready[NUM_PLANES] = m_tready;
  assign m_tdata = {{(OUT_TDATA_W-1){1'b0}}, link_item[NUM_PLANES].vis};
  assign m_tuser = link_item[NUM_PLANES].vis & ~link_item[NUM_PLANES].needs_rebuild;

endmodule

[rtl/core/afc_checker.sv]
// ----------------------------------------------------------------------------
// afc_checker
// Port-level checks on the cull core, bound to the top level.
// ----------------------------------------------------------------------------
`include "aabb_frustum_cull_core_assert.svh"

module afc_checker
  import afc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,   // in_view, zero padding
  input  logic                   m_tuser    // render
);

  // A chunk marked for render must be in view
  `AFC_ASSERT(a_render_in_view, m_tvalid |-> (!m_tuser || m_tdata[0]), "render without in_view")

  // Padding bits of the result word stay clear
  `AFC_ASSERT(a_pad_zero, m_tvalid |-> (m_tdata[OUT_TDATA_W-1:1] == '0), "result padding not zero")

  // A stalled result holds
  `AFC_ASSERT(a_stall_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable({m_tdata, m_tuser})), "stall not held")

  // The row is empty straight after reset
  `AFC_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "result valid after reset")

endmodule

bind aabb_frustum_cull_core afc_checker u_afc_checker (.*);
